### rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must hold on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   `ASSERT_CLK(label, clk, rst, (1'b1 |-> (cond)), msg)

`endif

### rtl/wuau_pkg.sv
// package for the wide unsigned arithmetic unit: widths, operation and state codes
package wuau_pkg;

   localparam int OPERAND_WIDTH = 96;
   localparam int LOW_WIDTH     = 64;
   localparam int HIGH_WIDTH    = 32;
   localparam int UNIT_WIDTH    = OPERAND_WIDTH + 2;
   localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

   localparam logic [CNT_WIDTH-1:0] LAST_BIT = CNT_WIDTH'(OPERAND_WIDTH - 1);

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CALC,
      S_FINISH
   } state_type;

endpackage

### rtl/wide_unsigned_arith_unit.sv
// 96-bit unsigned add, subtract, shift-add multiply and restoring divide unit
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+------------------------
//  request | req_op, req_a_low/high, req_b_low/high       | req_valid / req_stall
//  result  | rsp_res_low/high, rsp_rem_low/high, rsp_flag | rsp_valid / rsp_stall
//
// add and subtract take a single adder step, multiply and divide take
// one pass through the shared 98-bit adder per operand bit, one bit per cycle
// req_stall is high from acceptance until the result moves into the output register
// the output register holds a result under rsp_stall while a new transaction is accepted
// synchronous active-high reset clears the sequencer and rsp_valid only
`include "assert_macros.svh"

module wide_unsigned_arith_unit
   import wuau_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_op,
   input  logic [LOW_WIDTH-1:0]  req_a_low,
   input  logic [HIGH_WIDTH-1:0] req_a_high,
   input  logic [LOW_WIDTH-1:0]  req_b_low,
   input  logic [HIGH_WIDTH-1:0] req_b_high,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [LOW_WIDTH-1:0]  rsp_res_low,
   output logic [HIGH_WIDTH-1:0] rsp_res_high,
   output logic [LOW_WIDTH-1:0]  rsp_rem_low,
   output logic [HIGH_WIDTH-1:0] rsp_rem_high,
   output logic                  rsp_flag
);

   state_type state_ff, state_in;

   op_type                   op_ff, op_in;
   logic [OPERAND_WIDTH-1:0] acc_ff, acc_in;
   logic [OPERAND_WIDTH-1:0] sh_ff, sh_in;
   logic [OPERAND_WIDTH-1:0] opd_ff, opd_in;
   logic [CNT_WIDTH-1:0]     cnt_ff, cnt_in;
   logic                     flag_ff, flag_in;

   logic                     out_valid_ff, out_valid_in;
   logic [OPERAND_WIDTH-1:0] out_res_ff, out_res_in;
   logic [OPERAND_WIDTH-1:0] out_rem_ff, out_rem_in;
   logic                     out_flag_ff, out_flag_in;

   logic load_en, step_en, finish_en, out_free;

   logic [UNIT_WIDTH-2:0] unit_x, unit_y;
   logic                  unit_sub;
   logic [UNIT_WIDTH-1:0] unit_sum;

   logic [OPERAND_WIDTH-1:0] a_full, b_full;
   logic                     quot_bit;
   logic                     mul_ovf;

   assign a_full   = {req_a_high, req_a_low};
   assign b_full   = {req_b_high, req_b_low};
   assign out_free = !out_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_CALC;
         S_CALC:   if (cnt_ff == '0) state_in = S_FINISH;
         S_FINISH: if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      load_en   = 1'b0;
      step_en   = 1'b0;
      finish_en = 1'b0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            load_en   = req_valid;
         end
         S_CALC:   step_en = 1'b1;
         S_FINISH: finish_en = out_free;
         default: ;
      endcase
   end

   // shared adder / subtractor
   always_comb begin
      case (op_ff)
         OP_ADD: begin
            unit_x   = {1'b0, sh_ff};
            unit_y   = {1'b0, opd_ff};
            unit_sub = 1'b0;
         end
         OP_SUB: begin
            unit_x   = {1'b0, sh_ff};
            unit_y   = {1'b0, opd_ff};
            unit_sub = 1'b1;
         end
         OP_MUL: begin
            unit_x   = {1'b0, acc_ff};
            unit_y   = sh_ff[0] ? {1'b0, opd_ff} : '0;
            unit_sub = 1'b0;
         end
         default: begin
            unit_x   = {acc_ff, sh_ff[OPERAND_WIDTH-1]};
            unit_y   = {1'b0, opd_ff};
            unit_sub = 1'b1;
         end
      endcase
      unit_sum = {1'b0, unit_x} + ({1'b0, unit_y} ^ {UNIT_WIDTH{unit_sub}})
                 + {{(UNIT_WIDTH-1){1'b0}}, unit_sub};
   end

   assign quot_bit = !unit_sum[UNIT_WIDTH-1];
   assign mul_ovf  = |acc_ff;

   // datapath
   always_comb begin
      op_in   = op_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      opd_in  = opd_ff;
      cnt_in  = cnt_ff;
      flag_in = flag_ff;
      if (load_en) begin
         op_in   = op_type'(req_op);
         acc_in  = '0;
         flag_in = 1'b0;
         cnt_in  = LAST_BIT;
         sh_in   = a_full;
         opd_in  = b_full;
         case (op_type'(req_op)) inside
            OP_ADD, OP_SUB: cnt_in = '0;
            OP_MUL: begin
               sh_in  = b_full;
               opd_in = a_full;
            end
            default: ;
         endcase
      end else if (step_en) begin
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         case (op_ff)
            OP_ADD: begin
               sh_in   = unit_sum[OPERAND_WIDTH-1:0];
               flag_in = unit_sum[OPERAND_WIDTH];
            end
            OP_SUB: begin
               sh_in   = unit_sum[OPERAND_WIDTH-1:0];
               flag_in = unit_sum[UNIT_WIDTH-1];
            end
            OP_MUL: begin
               acc_in = unit_sum[OPERAND_WIDTH:1];
               sh_in  = {unit_sum[0], sh_ff[OPERAND_WIDTH-1:1]};
            end
            default: begin
               acc_in = quot_bit ? unit_sum[OPERAND_WIDTH-1:0] : unit_x[OPERAND_WIDTH-1:0];
               sh_in  = {sh_ff[OPERAND_WIDTH-2:0], quot_bit};
            end
         endcase
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_res_in   = out_res_ff;
      out_rem_in   = out_rem_ff;
      out_flag_in  = out_flag_ff;
      if (finish_en) begin
         out_valid_in = 1'b1;
         out_res_in   = sh_ff;
         out_rem_in   = '0;
         out_flag_in  = flag_ff;
         case (op_ff)
            OP_MUL: begin
               out_res_in  = mul_ovf ? '0 : sh_ff;
               out_flag_in = mul_ovf;
            end
            OP_DIV: begin
               out_rem_in  = acc_ff;
               out_flag_in = ~|opd_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      acc_ff      <= acc_in;
      sh_ff       <= sh_in;
      opd_ff      <= opd_in;
      cnt_ff      <= cnt_in;
      flag_ff     <= flag_in;
      out_res_ff  <= out_res_in;
      out_rem_ff  <= out_rem_in;
      out_flag_ff <= out_flag_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_res_low  = out_res_ff[LOW_WIDTH-1:0];
   assign rsp_res_high = out_res_ff[OPERAND_WIDTH-1:LOW_WIDTH];
   assign rsp_rem_low  = out_rem_ff[LOW_WIDTH-1:0];
   assign rsp_rem_high = out_rem_ff[OPERAND_WIDTH-1:LOW_WIDTH];
   assign rsp_flag     = out_flag_ff;

   `ASSERT_CLK(a_accept_starts, clock, reset, (req_valid && !req_stall) |=> (state_ff == S_CALC), "accepted transaction did not start the sequencer")
   `ASSERT_CLK(a_finish_loads, clock, reset, (state_ff == S_FINISH && (!rsp_valid || !rsp_stall)) |=> (rsp_valid && state_ff == S_IDLE), "finished transaction not moved to output")
   `ASSERT_ALWAYS(a_short_ops, clock, reset, !(state_ff == S_CALC && (op_ff == OP_ADD || op_ff == OP_SUB)) || cnt_ff == '0, "add or subtract took more than one step")

endmodule
